FILE: hw/rtl/sskt_pkg.sv
// Shared types and constants for the set-1 scancode key tracker.
package sskt_pkg;

    localparam int KEY_COUNT = 128;
    localparam int KEY_W     = $clog2(KEY_COUNT);
    localparam int MOD_W     = 4;
    localparam int LOCK_W    = 3;

    localparam logic [7:0] BYTE_ACK       = 8'hFA;
    localparam logic [7:0] BYTE_RESEND    = 8'hFE;
    localparam logic [7:0] BYTE_KBD_RESET = 8'd170;

    localparam logic [KEY_W-1:0] SC_CONTROL = KEY_W'(8'h1D);
    localparam logic [KEY_W-1:0] SC_LSHIFT  = KEY_W'(8'h2A);
    localparam logic [KEY_W-1:0] SC_RSHIFT  = KEY_W'(8'h36);
    localparam logic [KEY_W-1:0] SC_ALT     = KEY_W'(8'h38);
    localparam logic [KEY_W-1:0] SC_CAPS    = KEY_W'(8'h3A);
    localparam logic [KEY_W-1:0] SC_NUM     = KEY_W'(8'h45);
    localparam logic [KEY_W-1:0] SC_SCROLL  = KEY_W'(8'h46);
    localparam logic [KEY_W-1:0] SC_NUMDEL  = KEY_W'(8'h53);

    localparam int MOD_LSHIFT = 0;
    localparam int MOD_RSHIFT = 1;
    localparam int MOD_ALT    = 2;
    localparam int MOD_CTRL   = 3;

    localparam int LOCK_SCROLL = 0;
    localparam int LOCK_NUM    = 1;
    localparam int LOCK_CAPS   = 2;

    typedef enum logic [1:0] {
        KIND_KEY    = 2'd0,
        KIND_ACK    = 2'd1,
        KIND_RESEND = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MAP_PLAIN = 2'd0,
        MAP_SHIFT = 2'd1,
        MAP_ALTGR = 2'd2
    } map_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        kind_t              kind;
        logic [KEY_W-1:0]   key_code;
        logic               released;
        logic               wants_translation;
        map_t               map_select;
        logic [MOD_W-1:0]   mods;
        logic [LOCK_W-1:0]  leds;
        logic               led_update;
        logic               reboot_request;
    } result_t;

endpackage

FILE: hw/rtl/scancode_set1_key_tracker_core.sv
// Top level of the set-1 scancode key tracker: input register, tracker, result register.
// A byte beat is captured in the input register and its result is loaded into the result register.
// Throughput: one beat per cycle unless a result stall holds it; state updates on advance.
// A stalled result holds the input register, so at most one more input beat is captured
// before in_ready drops; a command beat still passes since it needs no result slot.
// Reset: asynchronous active-low rst_n clears the pressed map, modifiers, locks and reply arm.
module scancode_set1_key_tracker_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [6:0] key_code,
    output logic       released,
    output logic       wants_translation,
    output logic [1:0] map_select,
    output logic       lshift_down,
    output logic       rshift_down,
    output logic       alt_down,
    output logic       control_down,
    output logic [2:0] led_bits,
    output logic       led_update,
    output logic       reboot_request
);
    import sskt_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    has_result;
    logic    out_free;
    result_t result;
    result_t out_result;

    assign in_item.mode    = mode;
    assign in_item.rx_byte = rx_byte;

    // advance: a command beat needs no slot, a byte beat needs a free result register
    assign advance = item_valid && (item.mode || out_free);

    sskt_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sskt_tracker u_trk (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (item),
        .has_result (has_result),
        .result     (result)
    );

    sskt_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && has_result),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    assign kind              = out_result.kind;
    assign key_code          = out_result.key_code;
    assign released          = out_result.released;
    assign wants_translation = out_result.wants_translation;
    assign map_select        = out_result.map_select;
    assign lshift_down       = out_result.mods[MOD_LSHIFT];
    assign rshift_down       = out_result.mods[MOD_RSHIFT];
    assign alt_down          = out_result.mods[MOD_ALT];
    assign control_down      = out_result.mods[MOD_CTRL];
    assign led_bits          = out_result.leds;
    assign led_update        = out_result.led_update;
    assign reboot_request    = out_result.reboot_request;

    a_reply_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_KEY |->
            key_code == '0 && !released && !wants_translation && map_select == MAP_PLAIN)
        else $error("reply beat carries key fields");

    a_map_needs_xlat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !wants_translation |-> map_select == MAP_PLAIN)
        else $error("map selected without translation");

    a_reboot_mods: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reboot_request |-> alt_down && control_down && !released)
        else $error("reboot without alt and control");

    a_alt_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_KEY && released && key_code == SC_ALT |-> !alt_down)
        else $error("alt still held after its release");
endmodule

FILE: hw/rtl/sskt_in_stage.sv
// Input register holding one accepted beat until the tracker consumes it.
module sskt_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sskt_pkg::item_t in_item,
    input  logic            advance,
    output logic            item_valid,
    output sskt_pkg::item_t item
);
    import sskt_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

FILE: hw/rtl/sskt_tracker.sv
// Key state (pressed map, modifiers, locks, reply arm) and per-beat result logic.
module sskt_tracker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  sskt_pkg::item_t   item,
    output logic              has_result,
    output sskt_pkg::result_t result
);
    import sskt_pkg::*;

    logic [KEY_COUNT-1:0] pressed_reg;
    logic [KEY_COUNT-1:0] pressed_next;
    logic [MOD_W-1:0]     mods_reg;
    logic [MOD_W-1:0]     mods_next;
    logic [LOCK_W-1:0]    locks_reg;
    logic [LOCK_W-1:0]    locks_next;
    logic                 armed_reg;
    logic                 armed_next;

    logic [KEY_W-1:0]     key;
    logic                 rel;
    logic [MOD_W-1:0]     mbit;
    logic                 is_reply;

    assign key      = item.rx_byte[KEY_W-1:0];
    assign rel      = item.rx_byte[7];
    assign is_reply = armed_reg &&
                      (item.rx_byte == BYTE_ACK || item.rx_byte == BYTE_RESEND);

    always_comb
    begin
        mbit = '0;
        case (key)
            SC_LSHIFT:  mbit[MOD_LSHIFT] = 1'b1;
            SC_RSHIFT:  mbit[MOD_RSHIFT] = 1'b1;
            SC_ALT:     mbit[MOD_ALT]    = 1'b1;
            SC_CONTROL: mbit[MOD_CTRL]   = 1'b1;
            default:    mbit = '0;
        endcase
    end

    always_comb
    begin
        pressed_next = pressed_reg;
        mods_next    = mods_reg;
        locks_next   = locks_reg;
        armed_next   = armed_reg;
        has_result   = 1'b0;
        result       = '0;
        result.kind  = KIND_KEY;
        result.map_select = MAP_PLAIN;

        if (item.mode)
        begin
            armed_next = 1'b1;
        end
        else if (is_reply)
        begin
            has_result  = 1'b1;
            armed_next  = 1'b0;
            result.kind = (item.rx_byte == BYTE_ACK) ? KIND_ACK : KIND_RESEND;
        end
        else
        begin
            has_result        = 1'b1;
            result.key_code   = key;
            result.released   = rel;
            result.led_update = (item.rx_byte == BYTE_KBD_RESET);
            pressed_next[key] = !rel;
            if (!rel)
            begin
                case (key)
                    SC_CAPS:
                    begin
                        locks_next[LOCK_CAPS] = !locks_reg[LOCK_CAPS];
                        result.led_update     = 1'b1;
                    end
                    SC_NUM:
                    begin
                        locks_next[LOCK_NUM] = !locks_reg[LOCK_NUM];
                        result.led_update    = 1'b1;
                    end
                    SC_SCROLL:
                    begin
                        locks_next[LOCK_SCROLL] = !locks_reg[LOCK_SCROLL];
                        result.led_update       = 1'b1;
                    end
                    SC_NUMDEL:
                    begin
                        result.reboot_request = mods_reg[MOD_ALT] && mods_reg[MOD_CTRL];
                    end
                    default:
                    begin
                        if (mbit != '0)
                        begin
                            mods_next = mods_reg | mbit;
                        end
                        else
                        begin
                            result.wants_translation = 1'b1;
                        end
                    end
                endcase
            end
            else
            begin
                if (mbit != '0)
                begin
                    mods_next = mods_reg & ~mbit;
                end
                else
                begin
                    result.wants_translation = 1'b1;
                end
            end

            if (result.wants_translation)
            begin
                if (mods_next[MOD_LSHIFT] || mods_next[MOD_RSHIFT] || locks_next[LOCK_CAPS])
                begin
                    result.map_select = MAP_SHIFT;
                end
                else if (pressed_next[SC_ALT])
                begin
                    result.map_select = MAP_ALTGR;
                end
                else
                begin
                    result.map_select = MAP_PLAIN;
                end
            end
        end

        result.mods = mods_next;
        result.leds = locks_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= '0;
            mods_reg    <= '0;
            locks_reg   <= '0;
            armed_reg   <= 1'b0;
        end
        else if (advance)
        begin
            pressed_reg <= pressed_next;
            mods_reg    <= mods_next;
            locks_reg   <= locks_next;
            armed_reg   <= armed_next;
        end
    end
endmodule

FILE: hw/rtl/sskt_out_stage.sv
// Result register driving the output beat.
module sskt_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sskt_pkg::result_t result,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_ready,
    output sskt_pkg::result_t out_result
);
    import sskt_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;
endmodule
